// File: rtl/smtu_pkg.sv
package smtu_pkg;

	localparam int TIMER_SLOTS = 16;
	localparam int SLOT_W      = $clog2(TIMER_SLOTS);
	localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);

	localparam logic [31:0] NO_DEADLINE = 32'hffff_ffff;

	// operation codes on the func field
	localparam logic [2:0] FN_ALLOC   = 3'd0;
	localparam logic [2:0] FN_FREE    = 3'd1;
	localparam logic [2:0] FN_INIT    = 3'd2;
	localparam logic [2:0] FN_SETTIME = 3'd3;
	localparam logic [2:0] FN_TICK    = 3'd4;

	typedef enum logic [1:0] {
		ST_FREE,
		ST_ALLOC,
		ST_RUN
	} slot_st_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SRCH,
		S_NDL,
		S_TCHK,
		S_EXP
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic cap;        // capture input word
		logic do_alloc;
		logic do_free;
		logic do_init;
		logic do_set;
		logic do_tick;
		logic idx_clr;
		logic idx_inc;
		logic ins;        // insert slot at walk index
		logic ndl;        // refresh next deadline from list head
		logic exp_take;   // pop head into pending result
		logic push;       // pending result -> output register
		logic push_last;
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic [2:0] func;
		logic       slot_ok;
		logic       list_full;
		logic       srch_hit;
		logic       tick_early;
		logic       head_due;
		logic       pend_v;
		logic       out_free;
	} sts_t;

endpackage

// File: rtl/smtu_ctrl.sv
module smtu_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_ready,
	output smtu_pkg::ctl_t ctl,
	input  smtu_pkg::sts_t sts
);
	import smtu_pkg::*;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (item_valid) state_nx = S_EXEC;
			end
			S_EXEC: begin
				case (sts.func)
					FN_ALLOC: begin
						if (sts.out_free) state_nx = S_IDLE;
					end
					FN_SETTIME: begin
						if (sts.slot_ok && !sts.list_full) state_nx = S_SRCH;
						else state_nx = S_IDLE;
					end
					FN_TICK: state_nx = S_TCHK;
					default: state_nx = S_IDLE;
				endcase
			end
			S_SRCH: begin
				if (sts.srch_hit) state_nx = S_NDL;
			end
			S_NDL: state_nx = S_IDLE;
			S_TCHK: begin
				if (sts.tick_early) state_nx = S_IDLE;
				else state_nx = S_EXP;
			end
			S_EXP: begin
				if (!sts.head_due) begin
					if (!sts.pend_v || sts.out_free) state_nx = S_NDL;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ctl        = '0;
		item_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				ctl.cap    = item_valid;
			end
			S_EXEC: begin
				case (sts.func)
					FN_ALLOC: ctl.do_alloc = sts.out_free;
					FN_FREE:  ctl.do_free  = 1'b1;
					FN_INIT:  ctl.do_init  = 1'b1;
					FN_SETTIME: begin
						ctl.do_set  = sts.slot_ok && !sts.list_full;
						ctl.idx_clr = 1'b1;
					end
					FN_TICK: begin
						ctl.do_tick = 1'b1;
						ctl.idx_clr = 1'b1;
					end
					default: ;
				endcase
			end
			S_SRCH: begin
				if (sts.srch_hit) begin
					ctl.ins     = 1'b1;
					ctl.idx_clr = 1'b1;
				end else begin
					ctl.idx_inc = 1'b1;
				end
			end
			S_NDL: ctl.ndl = 1'b1;
			S_TCHK: ;
			S_EXP: begin
				if (sts.head_due) begin
					if (!sts.pend_v) begin
						ctl.exp_take = 1'b1;
					end else if (sts.out_free) begin
						ctl.exp_take = 1'b1;
						ctl.push     = 1'b1;
					end
				end else if (sts.pend_v && sts.out_free) begin
					ctl.push      = 1'b1;
					ctl.push_last = 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule

// File: rtl/smtu_dp.sv
module smtu_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  smtu_pkg::ctl_t ctl,
	output smtu_pkg::sts_t sts,
	input  logic [2:0]     func,
	input  logic [3:0]     slot,
	input  logic [31:0]    delay,
	input  logic [3:0]     channel,
	input  logic [7:0]     payload,
	output logic           result_valid,
	input  logic           result_ready,
	output logic           kind,
	output logic           ok,
	output logic [3:0]     slot_out,
	output logic [3:0]     channel_out,
	output logic [7:0]     payload_out,
	output logic           last
);
	import smtu_pkg::*;

	// captured input word
	logic [2:0]  func_q;
	logic [3:0]  slot_q;
	logic [31:0] delay_q;
	logic [3:0]  chan_q;
	logic [7:0]  pay_q;

	logic [31:0] tick_q;
	logic [31:0] ndl_q;
	logic [31:0] newdl_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;

	slot_st_t          status_q [TIMER_SLOTS];
	logic [31:0]       dl_q     [TIMER_SLOTS];
	logic [3:0]        ch_q     [TIMER_SLOTS];
	logic [7:0]        pl_q     [TIMER_SLOTS];
	logic [SLOT_W-1:0] list_q   [TIMER_SLOTS];

	logic              pend_v_q;
	logic [SLOT_W-1:0] pend_slot_q;
	logic [3:0]        pend_ch_q;
	logic [7:0]        pend_pl_q;

	logic              out_v_q;
	logic              kind_q;
	logic              ok_q;
	logic [3:0]        slot_out_q;
	logic [3:0]        ch_out_q;
	logic [7:0]        pl_out_q;
	logic              last_q;

	logic [SLOT_W-1:0] sidx;
	logic              slot_ok;
	logic [SLOT_W-1:0] rd_slot;
	logic [31:0]       rd_dl;
	logic [3:0]        rd_ch;
	logic [7:0]        rd_pl;
	logic [31:0]       sum_dl;
	logic              free_hit;
	logic [SLOT_W-1:0] free_idx;
	logic              out_free;

	assign sidx    = SLOT_W'(slot_q);
	assign slot_ok = 32'(slot_q) < 32'(TIMER_SLOTS);
	assign rd_slot = list_q[idx_q[SLOT_W-1:0]];
	assign rd_dl   = dl_q[rd_slot];
	assign rd_ch   = ch_q[rd_slot];
	assign rd_pl   = pl_q[rd_slot];
	assign sum_dl  = tick_q + delay_q;
	assign out_free = !out_v_q || result_ready;

	// lowest free slot
	always_comb begin
		free_hit = 1'b0;
		free_idx = '0;
		for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
			if (status_q[i] == ST_FREE) begin
				free_hit = 1'b1;
				free_idx = SLOT_W'(i);
			end
		end
	end

	always_comb begin
		sts.func       = func_q;
		sts.slot_ok    = slot_ok;
		sts.list_full  = count_q >= CNT_W'(TIMER_SLOTS);
		sts.srch_hit   = (idx_q == count_q) || (rd_dl >= newdl_q);
		sts.tick_early = ndl_q > tick_q;
		sts.head_due   = (count_q != '0) && (rd_dl <= tick_q);
		sts.pend_v     = pend_v_q;
		sts.out_free   = out_free;
	end

	always_ff @(posedge clk) begin
		if (ctl.cap) begin
			func_q  <= func;
			slot_q  <= slot;
			delay_q <= delay;
			chan_q  <= channel;
			pay_q   <= payload;
		end
		if (ctl.do_set) begin
			dl_q[sidx] <= sum_dl;
			newdl_q    <= sum_dl;
		end
		if (ctl.do_init && slot_ok) begin
			ch_q[sidx] <= chan_q;
			pl_q[sidx] <= pay_q;
		end
		if (ctl.ins) begin
			if (idx_q == '0) list_q[0] <= sidx;
			for (int j = 1; j < TIMER_SLOTS; j++) begin
				if (CNT_W'(j) == idx_q) list_q[j] <= sidx;
				else if (CNT_W'(j) > idx_q) list_q[j] <= list_q[j-1];
			end
		end else if (ctl.exp_take) begin
			for (int j = 0; j < TIMER_SLOTS - 1; j++) begin
				list_q[j] <= list_q[j+1];
			end
		end
		if (ctl.exp_take) begin
			pend_slot_q <= rd_slot;
			pend_ch_q   <= rd_ch;
			pend_pl_q   <= rd_pl;
		end
		if (ctl.do_alloc) begin
			kind_q     <= 1'b0;
			ok_q       <= free_hit;
			slot_out_q <= free_hit ? 4'(free_idx) : 4'd0;
			ch_out_q   <= 4'd0;
			pl_out_q   <= 8'd0;
			last_q     <= 1'b1;
		end else if (ctl.push) begin
			kind_q     <= 1'b1;
			ok_q       <= 1'b0;
			slot_out_q <= 4'(pend_slot_q);
			ch_out_q   <= pend_ch_q;
			pl_out_q   <= pend_pl_q;
			last_q     <= ctl.push_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TIMER_SLOTS; i++) status_q[i] <= ST_FREE;
			tick_q   <= '0;
			ndl_q    <= NO_DEADLINE;
			count_q  <= '0;
			idx_q    <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (ctl.do_alloc && free_hit) status_q[free_idx] <= ST_ALLOC;
			if (ctl.do_free && slot_ok) status_q[sidx] <= ST_FREE;
			if (ctl.do_set) status_q[sidx] <= ST_RUN;
			if (ctl.exp_take) status_q[rd_slot] <= ST_ALLOC;

			if (ctl.do_tick) tick_q <= tick_q + 32'd1;
			if (ctl.ndl) ndl_q <= (count_q != '0) ? rd_dl : NO_DEADLINE;

			if (ctl.ins) count_q <= count_q + CNT_W'(1);
			else if (ctl.exp_take) count_q <= count_q - CNT_W'(1);

			if (ctl.idx_clr) idx_q <= '0;
			else if (ctl.idx_inc) idx_q <= idx_q + CNT_W'(1);

			if (ctl.exp_take) pend_v_q <= 1'b1;
			else if (ctl.push || ctl.do_tick) pend_v_q <= 1'b0;

			if (ctl.do_alloc || ctl.push) out_v_q <= 1'b1;
			else if (result_ready) out_v_q <= 1'b0;
		end
	end

	assign result_valid = out_v_q;
	assign kind         = kind_q;
	assign ok           = ok_q;
	assign slot_out     = slot_out_q;
	assign channel_out  = ch_out_q;
	assign payload_out  = pl_out_q;
	assign last         = last_q;

	// list never overflows
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TIMER_SLOTS))
		else $error("active list count overflow");

	// a new result only lands in a free output register
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.push || ctl.do_alloc) |-> out_free)
		else $error("result overwrites undelivered word");

	// insert only with room, pop only from a non-empty list
	a_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.ins |-> count_q < CNT_W'(TIMER_SLOTS)) and
		(ctl.exp_take |-> count_q != '0))
		else $error("list insert/pop out of bounds");

	// expiry walk works from the list head
	a_exp_head: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.exp_take || ctl.ndl) |-> idx_q == '0)
		else $error("expiry walk not at list head");

	// tick advances the counter by one
	a_tick_inc: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.do_tick |=> tick_q == $past(tick_q) + 32'd1)
		else $error("tick count step wrong");

endmodule

// File: rtl/sorted_multi_timer_unit_core.sv
// Channel  | Handshake                    | Words
// ---------+------------------------------+--------------------------------------------
// item     | item_valid / item_ready      | func, slot, delay, channel, payload
// result   | result_valid / result_ready  | kind, ok, slot_out, channel_out, payload_out,
//          |                              | last
//
// Sequencing: one item at a time. Free, init, unknown func and a dropped settime end
//   after decode; settime walks at most TIMER_SLOTS - 1 entries to its insert point, a
//   tick with entries due pops them, and both then refresh the next deadline. The insert
//   search, and the expiry pop while no held result stalls it, step one entry per cycle.
// Reset: arst_n clears counters, slot status (all free), list count and the output valid
//   flag; deadlines, channel/payload, list contents and output data stay unwritten.
// Stalls: item_ready is high whenever the sequencer is idle, also while a result word
//   waits; a held result stalls alloc and the expiry walk until result_ready.
module sorted_multi_timer_unit_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [2:0]  func,
	input  logic [3:0]  slot,
	input  logic [31:0] delay,
	input  logic [3:0]  channel,
	input  logic [7:0]  payload,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        kind,
	output logic        ok,
	output logic [3:0]  slot_out,
	output logic [3:0]  channel_out,
	output logic [7:0]  payload_out,
	output logic        last
);
	import smtu_pkg::*;

	ctl_t ctl;   // sequencer commands
	sts_t sts;   // datapath flags

	// sequencer: decode, insert search, expiry walk, next deadline refresh
	smtu_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.ctl        (ctl),
		.sts        (sts)
	);

	// slot tables, sorted list, tick counter, pending and output registers
	smtu_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.func         (func),
		.slot         (slot),
		.delay        (delay),
		.channel      (channel),
		.payload      (payload),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.kind         (kind),
		.ok           (ok),
		.slot_out     (slot_out),
		.channel_out  (channel_out),
		.payload_out  (payload_out),
		.last         (last)
	);

endmodule
